// ----- rtl/acel_pkg.sv -----
// acel_pkg: shared types, constants and the credit table of the ack credit unit
// no dependencies; used by every module under rtl/
`timescale 1ns / 1ps
`default_nettype none

package acel_pkg;

    localparam int SEQ_BITS        = 24;
    localparam int RING_INDEX_BITS = 16;
    localparam int SIZE_BITS       = 16;
    localparam int CODE_BITS       = 5;
    localparam int CREDIT_BITS     = 16;
    localparam int ACK_BITS        = 32;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 1;

    // credit code field of an ack word
    localparam int CODE_LSB = SEQ_BITS;
    localparam int CODE_MSB = SEQ_BITS + CODE_BITS - 1;

    localparam logic [CODE_BITS-1:0] CODE_INVALID = 5'd31;
    localparam logic [CODE_BITS-1:0] CODE_MAX     = 5'd30;

    localparam logic [SIZE_BITS-1:0] RQ_SIZE_RESET = 16'd256;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RQ_SIZE   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHARED_RQ = 1'b1;

    typedef enum logic [1:0] {
        ACT_BUILD = 2'd0,
        ACT_TAKE  = 2'd1,
        ACT_WAIT  = 2'd2
    } action_t;

    // credit-limit state after one item, handed to the result stage
    typedef struct packed {
        logic [SEQ_BITS-1:0] limit;
        logic                unlimited;
        logic                wake;
    } limit_status_t;

    // credits granted by each code; the invalid code grants none
    function automatic logic [CREDIT_BITS-1:0] credit_of_code(input logic [CODE_BITS-1:0] code);
        logic [CREDIT_BITS-1:0] credit;
        case (code)
            5'd0:    credit = 16'd0;
            5'd1:    credit = 16'd1;
            5'd2:    credit = 16'd2;
            5'd3:    credit = 16'd3;
            5'd4:    credit = 16'd4;
            5'd5:    credit = 16'd6;
            5'd6:    credit = 16'd8;
            5'd7:    credit = 16'd12;
            5'd8:    credit = 16'd16;
            5'd9:    credit = 16'd24;
            5'd10:   credit = 16'd32;
            5'd11:   credit = 16'd48;
            5'd12:   credit = 16'd64;
            5'd13:   credit = 16'd96;
            5'd14:   credit = 16'd128;
            5'd15:   credit = 16'd192;
            5'd16:   credit = 16'd256;
            5'd17:   credit = 16'd384;
            5'd18:   credit = 16'd512;
            5'd19:   credit = 16'd768;
            5'd20:   credit = 16'd1024;
            5'd21:   credit = 16'd1536;
            5'd22:   credit = 16'd2048;
            5'd23:   credit = 16'd3072;
            5'd24:   credit = 16'd4096;
            5'd25:   credit = 16'd6144;
            5'd26:   credit = 16'd8192;
            5'd27:   credit = 16'd12288;
            5'd28:   credit = 16'd16384;
            5'd29:   credit = 16'd24576;
            5'd30:   credit = 16'd32768;
            default: credit = 16'd0;
        endcase
        return credit;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ack_credit_encode_and_limit.sv -----
// ack_credit_encode_and_limit: top level, input and result registers, config
// depends on acel_pkg, acel_encode, acel_limit
`timescale 1ns / 1ps
`default_nettype none

// End-to-end credit unit for one reliable queue pair. Every accepted item
// gives exactly one result item. Action build packs the receive ring's
// free-credit code (or the invalid code when a shared receive queue is
// configured) above msn in ack_word; action take reads ack_in and, if not yet
// unlimited, switches to unlimited mode or raises the 24-bit send limit when
// ahead, setting wake_sender if a waiting sender is released; action wait
// marks the sender as waiting. limit_out and unlimited_out always show the
// state after the item. Throughput is one item per clock while m_ready does
// not stall the result register: an item sits in the input register, passes
// through the ring clamp, credit encoder and limit compare, and lands in the
// result register, which drives m_valid. The limit state is updated as the
// item moves into the result register, so the next item already sees it.
// rq_size and shared_rq reset to 256 and 0; the user must write them through
// cfg_wr_en/cfg_index/cfg_data only while the block is idle (not enforced).
module ack_credit_encode_and_limit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // configuration writes
    input  wire logic                                 cfg_wr_en,
    input  wire logic [acel_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [acel_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    // input items
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [1:0]                           s_action,
    input  wire logic [acel_pkg::SEQ_BITS-1:0]        s_msn,
    input  wire logic [acel_pkg::RING_INDEX_BITS-1:0] s_rq_head,
    input  wire logic [acel_pkg::RING_INDEX_BITS-1:0] s_rq_tail,
    input  wire logic [acel_pkg::ACK_BITS-1:0]        s_ack_in,

    // result items
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic      [acel_pkg::ACK_BITS-1:0]        m_ack_word,
    output logic      [acel_pkg::SEQ_BITS-1:0]        m_limit_out,
    output logic                                      m_unlimited_out,
    output logic                                      m_wake_sender
);

    // configuration registers
    logic [acel_pkg::SIZE_BITS-1:0] rq_size_reg;
    logic                           shared_rq_reg;

    // input register
    logic                                 in_valid_reg;
    logic [1:0]                           in_action_reg;
    logic [acel_pkg::SEQ_BITS-1:0]        in_msn_reg;
    logic [acel_pkg::RING_INDEX_BITS-1:0] in_head_reg;
    logic [acel_pkg::RING_INDEX_BITS-1:0] in_tail_reg;
    logic [acel_pkg::ACK_BITS-1:0]        in_ack_reg;

    // result register
    logic                                 out_valid_reg;
    logic [acel_pkg::ACK_BITS-1:0]        out_word_reg;
    logic [acel_pkg::SEQ_BITS-1:0]        out_limit_reg;
    logic                                 out_unlimited_reg;
    logic                                 out_wake_reg;

    logic                                 out_free;
    logic                                 advance;
    logic [acel_pkg::ACK_BITS-1:0]        enc_word;
    logic [acel_pkg::ACK_BITS-1:0]        ack_word_next;
    acel_pkg::limit_status_t              lim_status;

    // result slot empties this cycle or already is empty
    assign out_free = !out_valid_reg || m_ready;
    // item in the input register moves into the result register
    assign advance  = in_valid_reg && out_free;
    // input register can take a new item while the held one moves on
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rq_size_reg   <= acel_pkg::RQ_SIZE_RESET;
            shared_rq_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                acel_pkg::CFG_RQ_SIZE:   rq_size_reg   <= cfg_data;
                acel_pkg::CFG_SHARED_RQ: shared_rq_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input stage payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_msn_reg    <= s_msn;
            in_head_reg   <= s_rq_head;
            in_tail_reg   <= s_rq_tail;
            in_ack_reg    <= s_ack_in;
        end
    end

    acel_encode u_encode (
        .msn       (in_msn_reg),
        .rq_head   (in_head_reg),
        .rq_tail   (in_tail_reg),
        .rq_size   (rq_size_reg),
        .shared_rq (shared_rq_reg),
        .ack_word  (enc_word)
    );

    acel_limit u_limit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .action  (in_action_reg),
        .ack_in  (in_ack_reg),
        .status  (lim_status)
    );

    // ack word only for build, zero for every other action
    assign ack_word_next = (in_action_reg == acel_pkg::ACT_BUILD) ? enc_word : '0;

    // result stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result stage payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg      <= ack_word_next;
            out_limit_reg     <= lim_status.limit;
            out_unlimited_reg <= lim_status.unlimited;
            out_wake_reg      <= lim_status.wake;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_ack_word      = out_word_reg;
    assign m_limit_out     = out_limit_reg;
    assign m_unlimited_out = out_unlimited_reg;
    assign m_wake_sender   = out_wake_reg;

    // a held input item must not be lost or changed while the result side stalls
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_ack_reg)
                                      && $stable(in_action_reg))
        else $error("input stage dropped or changed a stalled item");

    // unlimited mode is sticky until reset
    a_unlimited_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_unlimited_reg && out_valid_reg |-> lim_status.unlimited)
        else $error("unlimited mode cleared without reset");

    // only a take action may wake the sender
    a_wake_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && lim_status.wake |-> in_action_reg == acel_pkg::ACT_TAKE)
        else $error("sender woken by a non-take item");

    // shared receive queue always advertises the invalid code on build
    a_shared_code: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && shared_rq_reg && in_action_reg == acel_pkg::ACT_BUILD
        |=> out_word_reg[acel_pkg::CODE_MSB:acel_pkg::CODE_LSB] == acel_pkg::CODE_INVALID)
        else $error("shared queue built a credit code other than invalid");

endmodule

`default_nettype wire

// ----- rtl/acel_encode.sv -----
// acel_encode: builds the outgoing ack word from ring indexes and msn
// depends on acel_pkg (credit table, widths)
`timescale 1ns / 1ps
`default_nettype none

module acel_encode (
    input  wire logic [acel_pkg::SEQ_BITS-1:0]        msn,
    input  wire logic [acel_pkg::RING_INDEX_BITS-1:0] rq_head,
    input  wire logic [acel_pkg::RING_INDEX_BITS-1:0] rq_tail,
    input  wire logic [acel_pkg::SIZE_BITS-1:0]       rq_size,
    input  wire logic                                 shared_rq,
    output logic      [acel_pkg::ACK_BITS-1:0]        ack_word
);

    logic [acel_pkg::SIZE_BITS-1:0] head;
    logic [acel_pkg::SIZE_BITS-1:0] tail;
    logic [acel_pkg::SIZE_BITS-1:0] wrap_sum;
    logic [acel_pkg::SIZE_BITS-1:0] free_count;
    logic [acel_pkg::CODE_BITS-1:0] code;

    always_comb begin
        // out-of-range indexes count as zero
        head = (rq_head < rq_size) ? rq_head : '0;
        tail = (rq_tail < rq_size) ? rq_tail : '0;
        // wrapped count stays below rq_size, so it fits the size width
        wrap_sum = head + rq_size - tail;
        if (head >= tail) begin
            free_count = head - tail;
        end else begin
            free_count = wrap_sum;
        end
    end

    // largest code whose credit fits, table is monotonic
    always_comb begin
        code = '0;
        for (int k = 1; k <= 30; k++) begin
            if (acel_pkg::credit_of_code(k[acel_pkg::CODE_BITS-1:0]) <= free_count) begin
                code = k[acel_pkg::CODE_BITS-1:0];
            end
        end
        if (shared_rq) begin
            code = acel_pkg::CODE_INVALID;
        end
    end

    assign ack_word = {{(acel_pkg::ACK_BITS - acel_pkg::CODE_MSB - 1){1'b0}}, code, msn};

endmodule

`default_nettype wire

// ----- rtl/acel_limit.sv -----
// acel_limit: send limit, unlimited mode and waiting-sender state
// depends on acel_pkg (action codes, status struct, credit table)
`timescale 1ns / 1ps
`default_nettype none

module acel_limit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            fire,
    input  wire logic [1:0]                      action,
    input  wire logic [acel_pkg::ACK_BITS-1:0]   ack_in,
    output acel_pkg::limit_status_t              status
);

    logic [acel_pkg::SEQ_BITS-1:0]  send_limit_reg, send_limit_next;
    logic                           unlimited_reg, unlimited_next;
    logic                           waiting_reg, waiting_next;
    logic                           wake;

    logic [acel_pkg::CODE_BITS-1:0] code;
    logic [acel_pkg::SEQ_BITS-1:0]  cand;
    logic [acel_pkg::SEQ_BITS-1:0]  diff;
    logic                           ahead;

    assign code  = ack_in[acel_pkg::CODE_MSB:acel_pkg::CODE_LSB];
    assign cand  = ack_in[acel_pkg::SEQ_BITS-1:0]
                 + {{(acel_pkg::SEQ_BITS - acel_pkg::CREDIT_BITS){1'b0}},
                    acel_pkg::credit_of_code(code)};
    assign diff  = cand - send_limit_reg;
    // serial compare: ahead by 1 to half the sequence space minus one
    assign ahead = (diff != '0) && !diff[acel_pkg::SEQ_BITS-1];

    always_comb begin
        send_limit_next = send_limit_reg;
        unlimited_next  = unlimited_reg;
        waiting_next    = waiting_reg;
        wake            = 1'b0;
        case (action)
            acel_pkg::ACT_TAKE: begin
                if (!unlimited_reg) begin
                    if (code == acel_pkg::CODE_INVALID) begin
                        unlimited_next = 1'b1;
                        wake           = waiting_reg;
                        waiting_next   = 1'b0;
                    end else if (ahead) begin
                        send_limit_next = cand;
                        wake            = waiting_reg;
                        waiting_next    = 1'b0;
                    end
                end
            end
            acel_pkg::ACT_WAIT: begin
                waiting_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_limit_reg <= '0;
            unlimited_reg  <= 1'b0;
            waiting_reg    <= 1'b0;
        end else if (fire) begin
            send_limit_reg <= send_limit_next;
            unlimited_reg  <= unlimited_next;
            waiting_reg    <= waiting_next;
        end
    end

    assign status.limit     = send_limit_next;
    assign status.unlimited = unlimited_next;
    assign status.wake      = wake;

endmodule

`default_nettype wire

// ----- tb/sv/tb_ack_credit_encode_and_limit.sv -----
// tb_ack_credit_encode_and_limit: self-checking bench for the ack credit unit
// drives build, take, wait and no-op items with random idling, predicts every result
// depends on acel_pkg and ack_credit_encode_and_limit
`timescale 1ns / 1ps

module tb_ack_credit_encode_and_limit;
    import acel_pkg::*;

    // action code with no meaning to the block
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int SEQ_MOD       = 1 << SEQ_BITS;
    localparam int HALF_WINDOW   = 1 << (SEQ_BITS - 1);
    localparam int PHASE_ITEMS   = 66;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [1:0]                 action;
        logic [SEQ_BITS-1:0]        msn;
        logic [RING_INDEX_BITS-1:0] head;
        logic [RING_INDEX_BITS-1:0] tail;
        logic [ACK_BITS-1:0]        ack;
    } credit_item_t;

    typedef struct packed {
        logic [ACK_BITS-1:0] ack_word;
        logic [SEQ_BITS-1:0] limit;
        logic                unlimited;
        logic                wake;
    } credit_result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // block ports, all known from time zero
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data  = '0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic [1:0]                  s_action  = '0;
    logic [SEQ_BITS-1:0]         s_msn     = '0;
    logic [RING_INDEX_BITS-1:0]  s_rq_head = '0;
    logic [RING_INDEX_BITS-1:0]  s_rq_tail = '0;
    logic [ACK_BITS-1:0]         s_ack_in  = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic [ACK_BITS-1:0]         m_ack_word;
    logic [SEQ_BITS-1:0]         m_limit_out;
    logic                        m_unlimited_out;
    logic                        m_wake_sender;

    ack_credit_encode_and_limit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_msn           (s_msn),
        .s_rq_head       (s_rq_head),
        .s_rq_tail       (s_rq_tail),
        .s_ack_in        (s_ack_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ack_word      (m_ack_word),
        .m_limit_out     (m_limit_out),
        .m_unlimited_out (m_unlimited_out),
        .m_wake_sender   (m_wake_sender)
    );

    // items waiting to be offered, and ack results owed by the block
    credit_item_t   items_todo[$];
    credit_result_t acks_due[$];
    credit_item_t   item_on_wire;

    // predicted credit state and register copies
    logic [SEQ_BITS-1:0] limit_now     = '0;
    logic                unlimited_now = 1'b0;
    logic                waiting_now   = 1'b0;
    int                  ring_size_now = RQ_SIZE_RESET;
    logic                shared_now    = 1'b0;

    // idling percentages, long receiver hold-off, bookkeeping
    int          send_idle_pct = 30;
    int          recv_idle_pct = 86;
    int unsigned hold_off_left = 0;
    int          mismatches    = 0;
    int          cycles        = 0;

    // credits granted by a code: 0,1,2,3 then alternating 2^n and 3*2^(n-1)
    function automatic int credits_of(input logic [CODE_BITS-1:0] code);
        int c;
        c = int'(code);
        if (code == CODE_INVALID) return 0;
        if (c < 2) return c;
        if (code[0]) return 3 << ((c - 3) / 2);
        return 2 << ((c - 2) / 2);
    endfunction

    // largest code whose credit fits in the free count
    function automatic logic [CODE_BITS-1:0] code_for_free(input int free_cnt);
        logic [CODE_BITS-1:0] code;
        code = '0;
        for (int k = 1; k <= int'(CODE_MAX); k++) begin
            if (credits_of(CODE_BITS'(k)) <= free_cnt) code = CODE_BITS'(k);
        end
        return code;
    endfunction

    // work out the result of one accepted item and advance the credit state
    task automatic predict_ack_result(input credit_item_t it);
        credit_result_t r;
        int h, t, free_cnt;
        logic [CODE_BITS-1:0] code;
        logic [SEQ_BITS-1:0] cand, gap;
        r = '0;
        case (it.action)
            ACT_BUILD: begin
                if (shared_now) begin
                    code = CODE_INVALID;
                end else begin
                    h = int'(it.head);
                    t = int'(it.tail);
                    // out-of-range indexes count as zero
                    if (h >= ring_size_now) h = 0;
                    if (t >= ring_size_now) t = 0;
                    free_cnt = (h >= t) ? h - t : h + ring_size_now - t;
                    code = code_for_free(free_cnt);
                end
                r.ack_word = {3'b000, code, it.msn};
            end
            ACT_TAKE: begin
                if (!unlimited_now) begin
                    code = it.ack[CODE_MSB:CODE_LSB];
                    if (code == CODE_INVALID) begin
                        unlimited_now = 1'b1;
                        r.wake        = waiting_now;
                        waiting_now   = 1'b0;
                    end else begin
                        cand = it.ack[SEQ_BITS-1:0] + SEQ_BITS'(credits_of(code));
                        gap  = cand - limit_now;
                        // serial compare: only a limit strictly ahead moves it
                        if (gap != 0 && gap < HALF_WINDOW) begin
                            limit_now   = cand;
                            r.wake      = waiting_now;
                            waiting_now = 1'b0;
                        end
                    end
                end
            end
            ACT_WAIT: waiting_now = 1'b1;
            default: ;
        endcase
        r.limit     = limit_now;
        r.unlimited = unlimited_now;
        acks_due.push_back(r);
    endtask

    // received ack word that lands the new limit gap ahead of the current one
    function automatic logic [ACK_BITS-1:0] ack_with_gap(input logic [CODE_BITS-1:0] code,
                                                         input logic [SEQ_BITS-1:0] gap);
        logic [SEQ_BITS-1:0] seq;
        seq = limit_now + gap - SEQ_BITS'(credits_of(code));
        return {3'($urandom), code, seq};
    endfunction

    function automatic credit_item_t build_item(input logic [SEQ_BITS-1:0] msn,
                                                input logic [RING_INDEX_BITS-1:0] head,
                                                input logic [RING_INDEX_BITS-1:0] tail);
        credit_item_t it;
        it.action = ACT_BUILD;
        it.msn    = msn;
        it.head   = head;
        it.tail   = tail;
        it.ack    = $urandom;
        return it;
    endfunction

    function automatic credit_item_t plain_item(input logic [1:0] action);
        credit_item_t it;
        it.action = action;
        it.msn    = SEQ_BITS'($urandom);
        it.head   = RING_INDEX_BITS'($urandom);
        it.tail   = RING_INDEX_BITS'($urandom);
        it.ack    = $urandom;
        return it;
    endfunction

    // gap to the current limit: zero, edges of the serial window, behind, random
    function automatic logic [SEQ_BITS-1:0] random_gap();
        case ($urandom_range(9))
            0: return '0;
            1: return SEQ_BITS'(1);
            2: return SEQ_BITS'(HALF_WINDOW - 1);
            3: return SEQ_BITS'(HALF_WINDOW);
            4: return SEQ_BITS'(SEQ_MOD - 1);
            5: return SEQ_BITS'($urandom);
            default: return SEQ_BITS'($urandom_range(4000, 1));
        endcase
    endfunction

    function automatic logic [RING_INDEX_BITS-1:0] ring_edge();
        case ($urandom_range(3))
            0: return '0;
            1: return RING_INDEX_BITS'(ring_size_now - 1);
            2: return RING_INDEX_BITS'(ring_size_now);
            default: return '1;
        endcase
    endfunction

    function automatic credit_item_t random_item();
        credit_item_t it;
        int pick, free_cnt;
        it   = plain_item(ACT_NONE);
        pick = $urandom_range(99);
        if (pick < 45) begin
            it.action = ACT_BUILD;
            case ($urandom_range(3))
                0: ;
                1, 2: begin
                    // aim the free count at a credit table step
                    if (ring_size_now > 0) begin
                        it.tail  = RING_INDEX_BITS'($urandom_range(ring_size_now - 1));
                        free_cnt = credits_of(CODE_BITS'($urandom_range(30)))
                                   - $urandom_range(1);
                        if (free_cnt < 0) free_cnt = 0;
                        it.head = RING_INDEX_BITS'((int'(it.tail) + free_cnt) % ring_size_now);
                    end
                end
                default: begin
                    it.head = ring_edge();
                    it.tail = ring_edge();
                end
            endcase
        end else if (pick < 80) begin
            // the invalid code is kept for the end: unlimited mode is sticky
            it.action = ACT_TAKE;
            it.ack    = ack_with_gap(CODE_BITS'($urandom_range(30)), random_gap());
        end else if (pick < 95) begin
            it.action = ACT_WAIT;
        end
        return it;
    endfunction

    // every offered item has been taken by the block
    task automatic wait_accepted();
        while (items_todo.size() != 0 || s_valid) @(negedge aclk);
    endtask

    // nothing left to offer and nothing owed
    task automatic wait_drained();
        do @(negedge aclk);
        while (items_todo.size() != 0 || s_valid || acks_due.size() != 0);
    endtask

    // take items depend on the exact limit, so queue them once every offered item is taken
    task automatic queue_take(input logic [CODE_BITS-1:0] code,
                              input logic [SEQ_BITS-1:0] gap);
        wait_accepted();
        items_todo.push_back(plain_item(ACT_TAKE));
        items_todo[items_todo.size() - 1].ack = ack_with_gap(code, gap);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_RQ_SIZE) ring_size_now = value & 16'hFFFF;
        else shared_now = value[0];
    endtask

    // driver: offer the next queued item, keep valid and payload until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_ack_result(item_on_wire);
            if (!s_valid || s_ready) begin
                if (items_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_on_wire = items_todo.pop_front();
                    s_valid   <= 1'b1;
                    s_action  <= item_on_wire.action;
                    s_msn     <= item_on_wire.msn;
                    s_rq_head <= item_on_wire.head;
                    s_rq_tail <= item_on_wire.tail;
                    s_ack_in  <= item_on_wire.ack;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge aclk) begin
        if (hold_off_left != 0) hold_off_left <= hold_off_left - 1;
    end

    // monitor: compare each result with the oldest one owed
    always @(posedge aclk) begin
        credit_result_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_ack_word, m_limit_out, m_unlimited_out, m_wake_sender};
                if (acks_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t unexpected result: ack_word %h limit %h unl %b wake %b",
                                 $realtime, got.ack_word, got.limit, got.unlimited, got.wake);
                end else begin
                    want = acks_due.pop_front();
                    if (got.ack_word !== want.ack_word || got.limit !== want.limit ||
                        got.unlimited !== want.unlimited || got.wake !== want.wake) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t mismatch: ack_word %h/%h limit %h/%h unl %b/%b wake %b/%b",
                                     $realtime, want.ack_word, got.ack_word, want.limit,
                                     got.limit, want.unlimited, got.unlimited, want.wake,
                                     got.wake);
                    end
                end
            end
            m_ready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int rq_sizes[6];
        rq_sizes = '{16, 65535, 1, 256, 1000, 0};
        rq_sizes[5] = $urandom_range(65534, 2);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, default ring of 256 entries
        items_todo.push_back(build_item('0, 16'd0, 16'd0));          // empty ring
        items_todo.push_back(build_item('1, 16'd255, 16'd0));        // full ring
        items_todo.push_back(build_item(24'h123456, 16'd0, 16'd1));  // wrapped
        items_todo.push_back(build_item(24'h5a5a5a, 16'd300, 16'd5));// head out of range
        items_todo.push_back(build_item(24'ha5a5a5, 16'hffff, 16'hffff));
        items_todo.push_back(build_item(24'h000001, 16'd5, 16'd0));  // between steps
        items_todo.push_back(build_item(24'h800000, 16'd6, 16'd0));
        queue_take(5'd0, SEQ_BITS'(1));                              // smallest step ahead
        items_todo.push_back(plain_item(ACT_WAIT));
        queue_take(5'd7, SEQ_BITS'(HALF_WINDOW - 1));                // far edge, wakes
        items_todo.push_back(plain_item(ACT_WAIT));
        queue_take(5'd3, SEQ_BITS'(HALF_WINDOW));                    // not ahead
        queue_take(5'd12, '0);                                       // equal limit
        queue_take(CODE_MAX, SEQ_BITS'(5));                          // wakes waiter
        items_todo.push_back(plain_item(ACT_NONE));
        items_todo.push_back(plain_item(ACT_WAIT));
        items_todo.push_back(plain_item(ACT_NONE));
        queue_take(5'd1, SEQ_BITS'(SEQ_MOD - 1));                    // behind
        wait_drained();

        // largest ring: saturated code and the step just below it
        write_reg(CFG_RQ_SIZE, 65535);
        items_todo.push_back(build_item(24'h0f0f0f, 16'd65534, 16'd0));
        items_todo.push_back(build_item(24'hf0f0f0, 16'd0, 16'd65534));
        items_todo.push_back(build_item(24'h333333, 16'd40000, 16'd7232));
        items_todo.push_back(build_item(24'hcccccc, 16'd40000, 16'd7233));
        wait_drained();

        // zero ring size
        write_reg(CFG_RQ_SIZE, 0);
        items_todo.push_back(build_item(24'h777777, 16'd5, 16'd9));
        wait_drained();

        // shared receive queue advertises the invalid code
        write_reg(CFG_RQ_SIZE, 1);
        write_reg(CFG_SHARED_RQ, 1);
        items_todo.push_back(build_item(24'h888888, 16'd0, 16'd0));
        wait_drained();

        // random phases: receiver-heavy idling, sender-heavy idling, none
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 30;
                recv_idle_pct = 86;
            end else if (ph < 4) begin
                send_idle_pct = 86;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_RQ_SIZE, rq_sizes[ph]);
            write_reg(CFG_SHARED_RQ, (ph == 3) ? 1 : 0);
            if (ph == 4) begin
                // receiver stalls while the sender keeps offering
                @(posedge aclk);
                hold_off_left <= 400;
                @(negedge aclk);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                while (items_todo.size() >= 2) @(negedge aclk);
                items_todo.push_back(random_item());
            end
            wait_drained();
        end

        // unlimited mode is sticky, so it comes last
        items_todo.push_back(plain_item(ACT_WAIT));
        queue_take(CODE_INVALID, SEQ_BITS'($urandom));               // wakes, unlimited
        queue_take(5'd5, SEQ_BITS'(1));                              // ignored now
        items_todo.push_back(plain_item(ACT_WAIT));                  // still marks waiting
        queue_take(CODE_INVALID, '0);                                // no wake
        items_todo.push_back(build_item(24'h010203, 16'd3, 16'd1));
        wait_drained();

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/acel_pkg.sv
rtl/acel_encode.sv
rtl/acel_limit.sv
rtl/ack_credit_encode_and_limit.sv
tb/sv/tb_ack_credit_encode_and_limit.sv
